// ----- hdl/smpaq_pkg.sv -----
// Package for the stable max-priority admission queue: codes and types.
`timescale 1ns / 1ps
package smpaq_pkg;

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 3;
   localparam int COUNT_BITS  = 7;
   localparam int OUT_BITS    = 16;
   localparam int MAX_ADMIT   = 64;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH  = 2'd0,
      OP_ADMIT = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADMITTED = 3'd0,
      ST_PUSHED   = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,     // read parent of slot i
      S_UP_CMP,    // compare slot i against parent
      S_TOP_RD,    // read root
      S_TOP_OUT,   // present popped root
      S_MV_RD,     // read last slot
      S_MV_WR,     // write it to root
      S_DN_RDL,    // read left child
      S_DN_RDR,    // read right child
      S_DN_CMP,    // pick best of i, l, r
      S_RESP
   } state_type;

endpackage

// ----- hdl/smpaq_heap_mem.sv -----
// Heap storage: value and id per slot, one write and one registered read port.
`timescale 1ns / 1ps
module smpaq_heap_mem #(
   parameter int DEPTH = 1024,
   parameter int VW    = 16,
   parameter int IW    = 16,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [VW-1:0] wr_value,
   input  logic [IW-1:0] wr_id,
   input  logic [AW-1:0] rd_addr,
   output logic [VW-1:0] rd_value,
   output logic [IW-1:0] rd_id
);
   logic [VW+IW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_value, wr_id};
      end
      {rd_value, rd_id} <= mem[rd_addr];
   end
endmodule

// ----- hdl/stable_max_priority_admission_queue.sv -----
// Top level of the stable max-priority admission queue.
//
// Usage: an item enters on req_ (operation, value, count) when req_valid is
// high and req_stall low. op 0 pushes, op 1 admits up to count entries
// (count above 64 acts as 64), op 2 clears, op 3 does nothing. Results leave
// on rsp_ with rsp_last on the final result of an item; the receiver holds
// them back with rsp_stall and the result register simply waits.
// One item is handled at a time; req_stall is high while an item is at work.
// The heap lives in a single-port-write, registered-read memory, and one
// comparator does every sift step. A push writes the new entry at the end,
// then reads and compares against its parent once per level it rises (at
// most log2(QUEUE_DEPTH) levels); it is written at its resting slot in S_RESP.
// Each admitted entry is read from the root, replaced by the last slot, and
// sinks through S_DN_RDL, S_DN_RDR and S_DN_CMP once per level. A clear or
// a rejected push shows its result on the cycle after it is taken. Reset
// empties the queue and zeroes the arrival and admission counters; no memory
// pass is needed since only slots written since reset are ever used.
`timescale 1ns / 1ps
module stable_max_priority_admission_queue
   import smpaq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024,
   parameter int VALUE_BITS  = 16,
   parameter int ID_BITS     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [OUT_BITS-1:0]    req_value,
   input  logic [COUNT_BITS-1:0]  req_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [OUT_BITS-1:0]    rsp_entry_id,
   output logic [OUT_BITS-1:0]    rsp_entry_value,
   output logic [OUT_BITS-1:0]    rsp_admit_rank,
   output logic                   rsp_last
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = ID_BITS + 1;
   localparam int VW = VALUE_BITS;
   localparam int IW = ID_BITS;

   state_type state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [NW-1:0] arr_ff, arr_in;
   logic [OUT_BITS-1:0] rank_ff, rank_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [AW-1:0] i_ff, i_in;
   logic [VW-1:0] cv_ff, cv_in, bv_ff, bv_in;
   logic [IW-1:0] cid_ff, cid_in, bid_ff, bid_in;
   logic [AW-1:0] bidx_ff, bidx_in;
   logic          ovalid_ff, ovalid_in, olast_ff, olast_in;
   status_type    ost_ff, ost_in;
   logic [OUT_BITS-1:0] oid_ff, oid_in, oval_ff, oval_in, orank_ff, orank_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VW-1:0] wr_value, rd_value;
   logic [IW-1:0] wr_id, rd_id;

   smpaq_heap_mem #(.DEPTH(QUEUE_DEPTH), .VW(VW), .IW(IW), .AW(AW)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_value, .wr_id, .rd_addr, .rd_value, .rd_id
   );

   // shared comparator: does (ca_v, ca_id) leave before (cb_v, cb_id)?
   logic [VW-1:0] ca_v, cb_v;
   logic [IW-1:0] ca_id, cb_id;
   logic          a_ahead;
   assign a_ahead = (ca_v != cb_v) ? (ca_v > cb_v) : (ca_id < cb_id);

   logic accept, out_free;
   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   logic [AW-1:0] parent, lchild;
   logic [OW:0]   l_ext, r_ext;
   assign parent = AW'((i_ff - AW'(1)) >> 1);
   assign lchild = AW'({i_ff, 1'b1});
   assign l_ext  = (OW+1)'({i_ff, 1'b1});
   assign r_ext  = l_ext + (OW+1)'(1);

   always_comb begin
      state_in = state_ff; occ_in = occ_ff; arr_in = arr_ff; rank_in = rank_ff;
      left_in = left_ff; i_in = i_ff; cv_in = cv_ff; cid_in = cid_ff;
      bv_in = bv_ff; bid_in = bid_ff; bidx_in = bidx_ff;
      ovalid_in = ovalid_ff && rsp_stall; olast_in = olast_ff; ost_in = ost_ff;
      oid_in = oid_ff; oval_in = oval_ff; orank_in = orank_ff;
      wr_en = 1'b0; wr_addr = i_ff; wr_value = cv_ff; wr_id = cid_ff;
      rd_addr = parent;
      ca_v = cv_ff; ca_id = cid_ff; cb_v = rd_value; cb_id = rd_id;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_PUSH: begin
                     if ({1'b0, occ_ff} >= (OW+1)'(QUEUE_DEPTH) ||
                         arr_ff[NW-1]) begin
                        ovalid_in = 1'b1; ost_in = ST_DROPPED; oid_in = '0;
                        oval_in = OUT_BITS'(req_value[VW-1:0]);
                        orank_in = '0; olast_in = 1'b1;
                     end else begin
                        cv_in = req_value[VW-1:0];
                        cid_in = arr_ff[IW-1:0];
                        arr_in = arr_ff + NW'(1);
                        i_in = occ_ff[AW-1:0];
                        occ_in = occ_ff + OW'(1);
                        wr_en = 1'b1; wr_addr = occ_ff[AW-1:0];
                        wr_value = req_value[VW-1:0]; wr_id = arr_ff[IW-1:0];
                        ost_in = ST_PUSHED;
                        oid_in = OUT_BITS'(arr_ff[IW-1:0]);
                        oval_in = OUT_BITS'(req_value[VW-1:0]);
                        state_in = (occ_ff == '0) ? S_RESP : S_UP_RD;
                     end
                  end
                  OP_ADMIT: begin
                     if (req_count == '0 || occ_ff == '0) begin
                        ovalid_in = 1'b1; ost_in = ST_EMPTY; oid_in = '0;
                        oval_in = '0; orank_in = '0; olast_in = 1'b1;
                     end else begin
                        left_in = (req_count > COUNT_BITS'(MAX_ADMIT)) ?
                                  COUNT_BITS'(MAX_ADMIT) : req_count;
                        state_in = S_TOP_RD;
                     end
                  end
                  OP_CLEAR: begin
                     occ_in = '0; arr_in = '0; rank_in = '0;
                     ovalid_in = 1'b1; ost_in = ST_CLEARED; oid_in = '0;
                     oval_in = '0; orank_in = '0; olast_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_UP_RD: begin
            rd_addr = parent;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (a_ahead) begin
               // swap: parent drops to i, new entry goes up
               wr_en = 1'b1; wr_addr = i_ff; wr_value = rd_value; wr_id = rd_id;
               i_in = parent;
               state_in = (parent == '0) ? S_RESP : S_UP_RD;
            end else begin
               state_in = S_RESP;
            end
            if (state_in == S_RESP && a_ahead) begin
               // parent is root: entry stays at root, written in S_RESP
            end
         end
         S_RESP: begin
            // final write of the rising entry at its resting slot
            wr_en = (ost_ff == ST_PUSHED); wr_addr = i_ff;
            if (out_free) begin
               ovalid_in = 1'b1; olast_in = 1'b1; orank_in = '0;
               state_in = S_IDLE;
            end
         end
         S_TOP_RD: begin
            rd_addr = '0;
            state_in = S_TOP_OUT;
         end
         S_TOP_OUT: begin
            // keep the root on the read port while the result register waits
            rd_addr = '0;
            if (out_free) begin
               rank_in = rank_ff + OUT_BITS'(1);
               ovalid_in = 1'b1; ost_in = ST_ADMITTED;
               oid_in = OUT_BITS'(rd_id); oval_in = OUT_BITS'(rd_value);
               orank_in = rank_ff + OUT_BITS'(1);
               occ_in = occ_ff - OW'(1);
               left_in = left_ff - COUNT_BITS'(1);
               olast_in = (left_ff == COUNT_BITS'(1)) || (occ_ff == OW'(1));
               state_in = (occ_ff == OW'(1)) ? S_IDLE : S_MV_RD;
            end
         end
         S_MV_RD: begin
            rd_addr = occ_ff[AW-1:0];
            i_in = '0;
            state_in = S_MV_WR;
         end
         S_MV_WR: begin
            cv_in = rd_value; cid_in = rd_id;
            wr_en = 1'b1; wr_addr = '0; wr_value = rd_value; wr_id = rd_id;
            state_in = S_DN_RDL;
         end
         S_DN_RDL: begin
            // sinking entry lands at slot i
            wr_en = 1'b1; wr_addr = i_ff; wr_value = cv_ff; wr_id = cid_ff;
            bv_in = cv_ff; bid_in = cid_ff; bidx_in = i_ff;
            if (l_ext >= (OW+1)'(occ_ff)) begin
               state_in = (left_ff == '0) ? S_IDLE : S_TOP_RD;
            end else begin
               rd_addr = lchild;
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            // left child data arrives; compare against current
            ca_v = rd_value; ca_id = rd_id; cb_v = bv_ff; cb_id = bid_ff;
            if (a_ahead) begin
               bv_in = rd_value; bid_in = rd_id; bidx_in = lchild;
            end
            rd_addr = AW'(r_ext);
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            ca_v = rd_value; ca_id = rd_id; cb_v = bv_ff; cb_id = bid_ff;
            bidx_in = bidx_ff;
            if (r_ext < (OW+1)'(occ_ff) && a_ahead) begin
               bv_in = rd_value; bid_in = rd_id; bidx_in = AW'(r_ext);
            end
            if (bidx_in == i_ff) begin
               state_in = (left_ff == '0) ? S_IDLE : S_TOP_RD;
            end else begin
               // swap current with best child
               wr_en = 1'b1; wr_addr = i_ff;
               wr_value = bv_in; wr_id = bid_in;
               i_in = bidx_in;
               state_in = S_DN_RDL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; occ_ff <= '0; arr_ff <= '0; rank_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; occ_ff <= occ_in; arr_ff <= arr_in;
         rank_ff <= rank_in; ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in; i_ff <= i_in; cv_ff <= cv_in; cid_ff <= cid_in;
      bv_ff <= bv_in; bid_ff <= bid_in; bidx_ff <= bidx_in;
      olast_ff <= olast_in; ost_ff <= ost_in; oid_ff <= oid_in;
      oval_ff <= oval_in; orank_ff <= orank_in;
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_status      = ost_ff;
   assign rsp_entry_id    = oid_ff;
   assign rsp_entry_value = oval_ff;
   assign rsp_admit_rank  = orank_ff;
   assign rsp_last        = olast_ff;
endmodule

// ----- tb/sv/smpaq_checker.sv -----
// Checker for the admission queue: predicts each result and compares it.
`timescale 1ns / 1ps
module smpaq_checker
   import smpaq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024,
   parameter int ID_LIMIT    = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [OUT_BITS-1:0]    req_value,
   input  logic [COUNT_BITS-1:0]  req_count,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [STATUS_BITS-1:0] rsp_status,
   input  logic [OUT_BITS-1:0]    rsp_entry_id,
   input  logic [OUT_BITS-1:0]    rsp_entry_value,
   input  logic [OUT_BITS-1:0]    rsp_admit_rank,
   input  logic                   rsp_last,
   output int                     err_count,
   output int                     pending
);

   typedef struct {
      status_type          status;
      logic [OUT_BITS-1:0] entry_id;
      logic [OUT_BITS-1:0] entry_value;
      logic [OUT_BITS-1:0] admit_rank;
      logic                last;
   } admission_type;

   admission_type       due_results[$];
   logic [OUT_BITS-1:0] waiting_value [QUEUE_DEPTH];
   logic [OUT_BITS-1:0] waiting_id    [QUEUE_DEPTH];
   int                  waiting_count;
   int                  arrival_next;
   logic [OUT_BITS-1:0] admissions;

   function automatic admission_type mk(status_type s, logic [OUT_BITS-1:0] id,
                                        logic [OUT_BITS-1:0] v,
                                        logic [OUT_BITS-1:0] r, logic l);
      admission_type a;
      a.status = s; a.entry_id = id; a.entry_value = v; a.admit_rank = r; a.last = l;
      return a;
   endfunction

   // highest value first, earliest arrival among equals
   task automatic admit_entries(int limit);
      int best;
      int n;
      n = 0;
      while (n < limit && waiting_count > 0) begin
         best = 0;
         for (int i = 1; i < waiting_count; i++)
            if (waiting_value[i] > waiting_value[best] ||
                (waiting_value[i] == waiting_value[best] &&
                 waiting_id[i] < waiting_id[best]))
               best = i;
         admissions = admissions + 1'b1;
         due_results.push_back(mk(ST_ADMITTED, waiting_id[best], waiting_value[best],
                                  admissions, 1'b0));
         waiting_count--;
         waiting_value[best] = waiting_value[waiting_count];
         waiting_id[best]    = waiting_id[waiting_count];
         n++;
      end
      due_results[$].last = 1'b1;
   endtask

   task automatic predict_item(logic [OP_BITS-1:0] op, logic [OUT_BITS-1:0] v,
                               logic [COUNT_BITS-1:0] c);
      int limit;
      limit = (c > MAX_ADMIT) ? MAX_ADMIT : int'(c);
      case (op)
         OP_PUSH: begin
            if (waiting_count >= QUEUE_DEPTH || arrival_next >= ID_LIMIT) begin
               due_results.push_back(mk(ST_DROPPED, '0, v, '0, 1'b1));
            end else begin
               waiting_value[waiting_count] = v;
               waiting_id[waiting_count]    = arrival_next[OUT_BITS-1:0];
               waiting_count++;
               due_results.push_back(mk(ST_PUSHED, arrival_next[OUT_BITS-1:0], v,
                                        '0, 1'b1));
               arrival_next++;
            end
         end
         OP_ADMIT: begin
            if (limit == 0 || waiting_count == 0)
               due_results.push_back(mk(ST_EMPTY, '0, '0, '0, 1'b1));
            else
               admit_entries(limit);
         end
         OP_CLEAR: begin
            waiting_count = 0;
            arrival_next  = 0;
            admissions    = '0;
            due_results.push_back(mk(ST_CLEARED, '0, '0, '0, 1'b1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      admission_type e;
      if (reset) begin
         waiting_count = 0;
         arrival_next  = 0;
         admissions    = '0;
         due_results.delete();
         err_count     = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_item(req_operation, req_value, req_count);
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("%0t unexpected result: st %0d id %0d val %0d rank %0d last %0b",
                           $realtime, rsp_status, rsp_entry_id, rsp_entry_value,
                           rsp_admit_rank, rsp_last);
            end else begin
               e = due_results.pop_front();
               if (rsp_status !== e.status || rsp_entry_id !== e.entry_id ||
                   rsp_entry_value !== e.entry_value || rsp_admit_rank !== e.admit_rank ||
                   rsp_last !== e.last) begin
                  err_count++;
                  if (err_count <= 10)
                     $display({"%0t mismatch: exp st %0d id %0d val %0d rank %0d ",
                               "last %0b, got st %0d id %0d val %0d rank %0d last %0b"},
                              $realtime, e.status, e.entry_id, e.entry_value,
                              e.admit_rank, e.last, rsp_status, rsp_entry_id,
                              rsp_entry_value, rsp_admit_rank, rsp_last);
               end
            end
         end
      end
      pending = due_results.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: stimulus, receiver stalls and verdict for the admission queue.
`timescale 1ns / 1ps
module tb;
   import smpaq_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_BITS-1:0]     req_operation = OP_NOP;
   logic [OUT_BITS-1:0]    req_value = '0;
   logic [COUNT_BITS-1:0]  req_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [OUT_BITS-1:0]    rsp_entry_id;
   logic [OUT_BITS-1:0]    rsp_entry_value;
   logic [OUT_BITS-1:0]    rsp_admit_rank;
   logic                   rsp_last;
   int                     err_count;
   int                     pending;
   int                     cycles = 0;
   bit                     idle_on = 1'b1;
   bit                     hold_go = 1'b0;
   bit                     hold_done = 1'b0;
   int                     hold_cycles = 0;

   stable_max_priority_admission_queue i_dut (.*);

   smpaq_checker i_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, one long hold-off on request
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cycles++;
         if (hold_cycles >= 400)
            hold_done = 1'b1;
      end else if (idle_on)
         rsp_stall <= ($urandom_range(99) < 34);
      else
         rsp_stall <= 1'b0;
   end

   task automatic send(logic [OP_BITS-1:0] op, logic [OUT_BITS-1:0] v,
                       logic [COUNT_BITS-1:0] c);
      while (idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      req_count     <= c;
      #1;
      while (req_stall) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   initial begin
      int r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty admits, extremes, ties, saturation, clear
      send(OP_ADMIT, 16'h1234, 7'd5);
      send(OP_ADMIT, 16'h0, 7'd0);
      send(OP_PUSH, 16'h0000, 7'd0);
      send(OP_PUSH, 16'hFFFF, 7'h7F);
      send(OP_PUSH, 16'h5555, 7'd1);
      send(OP_PUSH, 16'hAAAA, 7'd2);
      send(OP_PUSH, 16'hFFFF, 7'd3);
      send(OP_PUSH, 16'h0000, 7'd4);
      send(OP_PUSH, 16'h0001, 7'd5);
      send(OP_PUSH, 16'h8000, 7'd6);
      send(OP_NOP, 16'hFFFF, 7'h7F);
      send(OP_ADMIT, 16'hFFFF, 7'd2);
      send(OP_ADMIT, 16'h0, 7'h7F);
      send(OP_PUSH, 16'h0003, 7'd0);
      send(OP_PUSH, 16'h0003, 7'd0);
      send(OP_ADMIT, 16'h0, 7'd1);
      send(OP_CLEAR, 16'hFFFF, 7'h7F);
      send(OP_ADMIT, 16'h0, 7'd1);
      send(OP_PUSH, 16'h0007, 7'd64);
      send(OP_ADMIT, 16'h0, 7'd65);

      for (int n = 0; n < 225; n++) begin
         if (n == 50)
            hold_go = 1'b1;
         if (n == 120)
            drain_results();
         idle_on = !(n >= 150 && n < 210);
         r = $urandom_range(99);
         if (r < 55)
            send(OP_PUSH, ($urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom)),
                 7'($urandom));
         else if (r < 88)
            send(OP_ADMIT, 16'($urandom),
                 ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(8, 1)));
         else if (r < 94)
            send(OP_CLEAR, 16'($urandom), 7'($urandom));
         else
            send(OP_NOP, 16'($urandom), 7'($urandom));
      end
      idle_on = 1'b1;

      send(OP_PUSH, 16'hBEEF, 7'd0);
      send(OP_ADMIT, 16'h0, 7'd1);
      send(OP_CLEAR, 16'h0, 7'd0);
      send(OP_PUSH, 16'hFFFF, 7'd0);

      drain_results();
      repeat (200) @(negedge clock);
      if (err_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule
